### rtl/core/nscc_pkg.sv
package nscc_pkg;

    // level class codes
    typedef enum logic [1:0] {
        CLS_BAND   = 2'd0,
        CLS_LEAD   = 2'd1,
        CLS_SHORT  = 2'd2,
        CLS_NORMAL = 2'd3
    } t_class;

    // fault kind codes on the result
    localparam logic [1:0] KIND_NONE       = 2'd0;
    localparam logic [1:0] KIND_LEAD_BREAK = 2'd1;
    localparam logic [1:0] KIND_SHORT      = 2'd2;

    // configuration register indexes
    localparam int unsigned CfgIdxBits = 3;
    localparam int unsigned CfgDataBits = 12;
    localparam logic [CfgIdxBits-1:0] CFG_LEAD_BREAK_MAX  = 3'd0;
    localparam logic [CfgIdxBits-1:0] CFG_SHORT_MIN       = 3'd1;
    localparam logic [CfgIdxBits-1:0] CFG_LATCH_ON_LEVEL  = 3'd2;
    localparam logic [CfgIdxBits-1:0] CFG_LATCH_OFF_LEVEL = 3'd3;
    localparam logic [CfgIdxBits-1:0] CFG_AVERAGE_SHIFT   = 3'd4;
    localparam logic [CfgIdxBits-1:0] CFG_DEBOUNCE_TARGET = 3'd5;

    typedef struct packed {
        logic [11:0] lead_break_max;
        logic [11:0] short_min;
        logic [11:0] latch_on_level;
        logic [11:0] latch_off_level;
        logic [3:0]  average_shift;
        logic [7:0]  debounce_target;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        lead_break_max:  12'd100,
        short_min:       12'd3900,
        latch_on_level:  12'd2000,
        latch_off_level: 12'd1500,
        average_shift:   4'd3,
        debounce_target: 8'd4
    };

    // switch word bit positions
    localparam int unsigned SwSuppress = 0;
    localparam int unsigned SwNcA      = 1;
    localparam int unsigned SwNcB      = 2;

endpackage

### rtl/core/namur_sensor_channel_conditioner_core.sv
// two-channel namur sensor input evaluation. every input beat carries one raw sample per
// channel and a 3-bit switch word (bit0 fault suppress, bit1/bit2 normally closed for channel
// one/two). each channel runs an exponential average, classifies the level (lead break, short,
// normal, hysteresis band), debounces the class, and drives a sense lamp or, on a stable fault,
// a blinking fault lamp with the fault kind. one beat is taken every clock cycle; its result
// appears in the output register in the following cycle, which is the only thing that can hold off
// the input: s_tready drops only while a result waits and m_tready is low. configuration
// writes take effect on the next beat and are meant to be done while no beat is in flight.
module namur_sensor_channel_conditioner_core
    import nscc_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS           = 12,
    parameter int unsigned LEAD_BREAK_HALF_TICKS = 250,
    parameter int unsigned SHORT_HALF_TICKS      = 100,
    localparam int unsigned InWidth = ((2 * SAMPLE_BITS + 3 + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // fields from bit 0: sample_a, sample_b, switch_word, zero pad
    input  logic [InWidth-1:0]     i_s_tdata,
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // fields from bit 0: sense_a, fault_lamp_a, fault_kind_a[1:0],
    // sense_b, fault_lamp_b, fault_kind_b[1:0]
    output logic [7:0]             o_m_tdata,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CfgIdxBits-1:0]  i_cfg_index,
    input  logic [CfgDataBits-1:0] i_cfg_data
);

    // compare width covers both the sample and the 12-bit thresholds
    localparam int unsigned LvlBits = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
    localparam logic [15:0] LbLast = 16'(LEAD_BREAK_HALF_TICKS - 1);
    localparam logic [15:0] ShLast = 16'(SHORT_HALF_TICKS - 1);

    t_cfg       r_cfg;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic [7:0] n_out_data;
    logic       w_accept;
    logic       w_suppress;
    logic [1:0] w_nc;
    logic [SAMPLE_BITS-1:0] w_sample [2];
    logic [1:0] w_sense;
    logic [1:0] w_lamp;
    logic [1:0] w_kind [2];

    // ---------------------------------------------------------------
    // handshake: output register parts the two sides
    // ---------------------------------------------------------------
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // unpack the input beat
    assign w_sample[0] = i_s_tdata[SAMPLE_BITS-1:0];
    assign w_sample[1] = i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_suppress  = i_s_tdata[2*SAMPLE_BITS+SwSuppress];
    assign w_nc[0]     = i_s_tdata[2*SAMPLE_BITS+SwNcA];
    assign w_nc[1]     = i_s_tdata[2*SAMPLE_BITS+SwNcB];

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEAD_BREAK_MAX:  r_cfg.lead_break_max  <= i_cfg_data;
                CFG_SHORT_MIN:       r_cfg.short_min       <= i_cfg_data;
                CFG_LATCH_ON_LEVEL:  r_cfg.latch_on_level  <= i_cfg_data;
                CFG_LATCH_OFF_LEVEL: r_cfg.latch_off_level <= i_cfg_data;
                CFG_AVERAGE_SHIFT:   r_cfg.average_shift   <= i_cfg_data[3:0];
                CFG_DEBOUNCE_TARGET: r_cfg.debounce_target <= i_cfg_data[7:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // per-channel evaluation, state updated on every accepted beat
    // ---------------------------------------------------------------
    for (genvar c = 0; c < 2; c++) begin : g_ch
        logic [SAMPLE_BITS-1:0] r_avg;
        t_class                 r_pend;
        t_class                 r_stab;
        logic [7:0]             r_cnt;
        logic                   r_latch;
        logic [15:0]            r_blink;
        // blink_ticks mod half and quotient parity, kept for both half periods
        // so a direct switch between fault kinds stays exact
        logic [15:0]            r_rem_lb;
        logic [15:0]            r_rem_sh;
        logic                   r_par_lb;
        logic                   r_par_sh;

        logic [SAMPLE_BITS-1:0]     n_avg;
        t_class                     n_pend;
        t_class                     n_stab;
        logic [7:0]                 n_cnt;
        logic                       n_latch;
        logic [15:0]                n_blink;
        logic [15:0]                n_rem_lb;
        logic [15:0]                n_rem_sh;
        logic                       n_par_lb;
        logic                       n_par_sh;
        logic signed [SAMPLE_BITS:0] w_diff;
        logic signed [SAMPLE_BITS:0] w_step;
        logic [LvlBits-1:0]         w_lvl;
        t_class                     w_cls;
        logic                       w_fault;
        logic                       w_on;
        logic                       w_off;

        // exponential average; arithmetic shift floors toward minus infinity
        assign w_diff = $signed({1'b0, w_sample[c]}) - $signed({1'b0, r_avg});
        assign w_step = w_diff >>> r_cfg.average_shift;
        assign n_avg  = r_avg + w_step[SAMPLE_BITS-1:0];
        assign w_lvl  = LvlBits'(n_avg);
        assign w_on   = w_lvl >= LvlBits'(r_cfg.latch_on_level);
        assign w_off  = w_lvl <= LvlBits'(r_cfg.latch_off_level);

        always_comb begin
            priority if (w_lvl <= LvlBits'(r_cfg.lead_break_max)) begin
                w_cls = CLS_LEAD;
            end else if (w_lvl >= LvlBits'(r_cfg.short_min)) begin
                w_cls = CLS_SHORT;
            end else if (w_on || w_off) begin
                w_cls = CLS_NORMAL;
            end else begin
                w_cls = CLS_BAND;
            end
        end

        // debounce: saturating run counter
        always_comb begin
            if (w_cls == r_pend) begin
                n_pend = r_pend;
                n_cnt  = (r_cnt < r_cfg.debounce_target) ? r_cnt + 8'd1 : r_cnt;
            end else begin
                n_pend = w_cls;
                n_cnt  = 8'd1;
            end
            n_stab = (n_cnt >= r_cfg.debounce_target) ? n_pend : r_stab;
        end

        assign w_fault = !w_suppress && (n_stab == CLS_LEAD || n_stab == CLS_SHORT);

        always_comb begin
            n_latch  = r_latch;
            n_blink  = 16'd0;
            n_rem_lb = 16'd0;
            n_rem_sh = 16'd0;
            n_par_lb = 1'b0;
            n_par_sh = 1'b0;
            if (!w_fault) begin
                // on-level test wins
                if (w_on) begin
                    n_latch = 1'b1;
                end else if (w_off) begin
                    n_latch = 1'b0;
                end
            end else begin
                n_blink = r_blink + 16'd1;
                // wrap of the tick counter restarts the quotient at zero
                if (n_blink != 16'd0) begin
                    if (r_rem_lb == LbLast) begin
                        n_par_lb = !r_par_lb;
                    end else begin
                        n_rem_lb = r_rem_lb + 16'd1;
                        n_par_lb = r_par_lb;
                    end
                    if (r_rem_sh == ShLast) begin
                        n_par_sh = !r_par_sh;
                    end else begin
                        n_rem_sh = r_rem_sh + 16'd1;
                        n_par_sh = r_par_sh;
                    end
                end
            end
        end

        assign w_sense[c] = !w_fault && (n_latch ^ w_nc[c]);
        assign w_lamp[c]  = w_fault && !((n_stab == CLS_LEAD) ? n_par_lb : n_par_sh);
        assign w_kind[c]  = !w_fault ? KIND_NONE :
                            (n_stab == CLS_LEAD) ? KIND_LEAD_BREAK : KIND_SHORT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_avg    <= '0;
                r_pend   <= CLS_BAND;
                r_stab   <= CLS_BAND;
                r_cnt    <= 8'd0;
                r_latch  <= 1'b0;
                r_blink  <= 16'd0;
                r_rem_lb <= 16'd0;
                r_rem_sh <= 16'd0;
                r_par_lb <= 1'b0;
                r_par_sh <= 1'b0;
            end else if (w_accept) begin
                r_avg    <= n_avg;
                r_pend   <= n_pend;
                r_stab   <= n_stab;
                r_cnt    <= n_cnt;
                r_latch  <= n_latch;
                r_blink  <= n_blink;
                r_rem_lb <= n_rem_lb;
                r_rem_sh <= n_rem_sh;
                r_par_lb <= n_par_lb;
                r_par_sh <= n_par_sh;
            end
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    assign n_out_data = {w_kind[1], w_lamp[1], w_sense[1], w_kind[0], w_lamp[0], w_sense[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    // an accepted beat always yields a result beat in the next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted beat produced no result");

    // sense lamp and fault lamp never lit together on one channel
    a_lamps_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[0] && r_out_data[1]) && !(r_out_data[4] && r_out_data[5]))
        else $error("sense and fault lamp both on");

    // fault lamp only with a fault kind, and sense off during a fault
    a_lamp_needs_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_data[1] || r_out_data[3:2] != KIND_NONE)
                     && (r_out_data[3:2] == KIND_NONE || !r_out_data[0])
                     && (!r_out_data[5] || r_out_data[7:6] != KIND_NONE)
                     && (r_out_data[7:6] == KIND_NONE || !r_out_data[4]))
        else $error("lamp state does not match fault kind");

    // fault kind code three is never produced
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_data[3:2] != 2'd3 && r_out_data[7:6] != 2'd3)
        else $error("illegal fault kind");
`endif

endmodule

### dv/nscc_scoreboard.sv
`timescale 1ns / 1ps

// watches both streams and the config port, keeps a model of the two
// conditioning channels, and compares every result beat with its prediction
module nscc_scoreboard
    import nscc_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS           = 12,
    parameter int unsigned LEAD_BREAK_HALF_TICKS = 250,
    parameter int unsigned SHORT_HALF_TICKS      = 100,
    localparam int unsigned InWidth = ((2 * SAMPLE_BITS + 3 + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [InWidth-1:0]     i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [7:0]             i_m_tdata,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxBits-1:0]  i_cfg_index,
    input  logic [CfgDataBits-1:0] i_cfg_data,
    output int                     o_error_count,
    output int                     o_outstanding
);

    localparam int unsigned SB = SAMPLE_BITS;

    t_cfg          regs;
    logic [SB-1:0] avg_level [2];
    t_class        pend_cls  [2];
    t_class        stab_cls  [2];
    logic [7:0]    deb_cnt   [2];
    logic          latch_q   [2];
    logic [15:0]   blink_cnt [2];

    logic [7:0] lamp_word_q [$];
    int         errors = 0;
    int         beats_seen = 0;

    assign o_error_count = errors;

    function automatic t_class level_class(input logic [SB-1:0] lvl);
        if (lvl <= regs.lead_break_max) return CLS_LEAD;
        if (lvl >= regs.short_min) return CLS_SHORT;
        if (lvl >= regs.latch_on_level || lvl <= regs.latch_off_level) return CLS_NORMAL;
        return CLS_BAND;
    endfunction

    // one channel tick; res holds sense, lamp, kind[1:0] from bit 0 up
    task automatic condition_channel(input int ch, input logic [SB-1:0] raw,
                                     input logic nc, input logic suppress,
                                     output logic [3:0] res);
        int          diff;
        int          nudge;
        int          sum;
        int unsigned half;
        t_class      cls;
        logic [1:0]  kind;
        logic        lamp;
        diff  = int'(raw) - int'(avg_level[ch]);
        // arithmetic shift on a signed int floors toward minus infinity
        nudge = diff >>> regs.average_shift;
        sum   = int'(avg_level[ch]) + nudge;
        avg_level[ch] = sum[SB-1:0];

        cls = level_class(avg_level[ch]);
        if (cls == pend_cls[ch]) begin
            if (deb_cnt[ch] < regs.debounce_target) deb_cnt[ch] = deb_cnt[ch] + 8'd1;
        end else begin
            pend_cls[ch] = cls;
            deb_cnt[ch]  = 8'd1;
        end
        if (deb_cnt[ch] >= regs.debounce_target) stab_cls[ch] = pend_cls[ch];

        kind = KIND_NONE;
        if (!suppress && stab_cls[ch] == CLS_LEAD) kind = KIND_LEAD_BREAK;
        if (!suppress && stab_cls[ch] == CLS_SHORT) kind = KIND_SHORT;

        if (kind == KIND_NONE) begin
            if (avg_level[ch] >= regs.latch_on_level) latch_q[ch] = 1'b1;
            else if (avg_level[ch] <= regs.latch_off_level) latch_q[ch] = 1'b0;
            blink_cnt[ch] = '0;
            res = {kind, 1'b0, latch_q[ch] ^ nc};
        end else begin
            half = (kind == KIND_LEAD_BREAK) ? LEAD_BREAK_HALF_TICKS : SHORT_HALF_TICKS;
            if (half == 0) half = 1;
            blink_cnt[ch] = blink_cnt[ch] + 16'd1;
            lamp = ((blink_cnt[ch] / half) % 2) == 0;
            res = {kind, lamp, 1'b0};
        end
    endtask

    task automatic flag(input string what, input int ch, input int want, input int got);
        errors = errors + 1;
        if (errors <= 10)
            $display("mismatch beat %0d ch %0d %s: expected %0d got %0d",
                     beats_seen, ch, what, want, got);
    endtask

    always @(posedge i_clk) begin : track
        logic [7:0] want;
        logic [3:0] res_a;
        logic [3:0] res_b;
        if (!i_rst_n) begin
            regs = CFG_RESET;
            for (int ch = 0; ch < 2; ch++) begin
                avg_level[ch] = '0;
                pend_cls[ch]  = CLS_BAND;
                stab_cls[ch]  = CLS_BAND;
                deb_cnt[ch]   = '0;
                latch_q[ch]   = 1'b0;
                blink_cnt[ch] = '0;
            end
            lamp_word_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (lamp_word_q.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("result beat %0d arrived with nothing expected: %h",
                                 beats_seen, i_m_tdata);
                end else begin
                    want = lamp_word_q.pop_front();
                    for (int ch = 0; ch < 2; ch++) begin
                        if (want[4*ch] !== i_m_tdata[4*ch])
                            flag("sense", ch, want[4*ch], i_m_tdata[4*ch]);
                        if (want[4*ch+1] !== i_m_tdata[4*ch+1])
                            flag("fault lamp", ch, want[4*ch+1], i_m_tdata[4*ch+1]);
                        if (want[4*ch+2 +: 2] !== i_m_tdata[4*ch+2 +: 2])
                            flag("fault kind", ch, want[4*ch+2 +: 2], i_m_tdata[4*ch+2 +: 2]);
                    end
                end
                beats_seen = beats_seen + 1;
            end
            if (i_s_tvalid && i_s_tready) begin
                condition_channel(0, i_s_tdata[SB-1:0], i_s_tdata[2*SB+SwNcA],
                                  i_s_tdata[2*SB+SwSuppress], res_a);
                condition_channel(1, i_s_tdata[2*SB-1:SB], i_s_tdata[2*SB+SwNcB],
                                  i_s_tdata[2*SB+SwSuppress], res_b);
                lamp_word_q.push_back({res_b, res_a});
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LEAD_BREAK_MAX:  regs.lead_break_max  = i_cfg_data[11:0];
                    CFG_SHORT_MIN:       regs.short_min       = i_cfg_data[11:0];
                    CFG_LATCH_ON_LEVEL:  regs.latch_on_level  = i_cfg_data[11:0];
                    CFG_LATCH_OFF_LEVEL: regs.latch_off_level = i_cfg_data[11:0];
                    CFG_AVERAGE_SHIFT:   regs.average_shift   = i_cfg_data[3:0];
                    CFG_DEBOUNCE_TARGET: regs.debounce_target = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        o_outstanding = lamp_word_q.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

// top of the bench: clock, reset, stimulus and the final verdict; all
// prediction and comparison lives in the scoreboard beside the dut
module tb
    import nscc_pkg::*;
();

    localparam int unsigned SampleBits = 12;
    localparam int unsigned InWidth    = ((2 * SampleBits + 3 + 7) / 8) * 8;
    localparam int unsigned LevelMax   = (1 << SampleBits) - 1;

    // level regions the sample generator aims at
    localparam int RegLead   = 0;
    localparam int RegShort  = 1;
    localparam int RegBand   = 2;
    localparam int RegHigh   = 3;
    localparam int RegLow    = 4;
    localparam int RegAny    = 5;
    localparam int RegFree   = -1;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // fields from bit 0: sample_a, sample_b, switch_word, zero pad
    logic [InWidth-1:0]     s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // fields from bit 0: sense_a, fault_lamp_a, fault_kind_a[1:0],
    // sense_b, fault_lamp_b, fault_kind_b[1:0]
    logic [7:0]             m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CfgIdxBits-1:0]  cfg_index = CFG_LEAD_BREAK_MAX;
    logic [CfgDataBits-1:0] cfg_data  = '0;

    int error_count;
    int outstanding;

    // idle percentages of both sides, stepped by the beat count
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int n_sent      = 0;

    // copy of the thresholds last written, used to aim the samples
    int lead_lvl  = 100;
    int short_lvl = 3900;
    int on_lvl    = 2000;
    int off_lvl   = 1500;

    // per-channel dwell target so the average settles and the debounce can finish
    int         hold_level [2];
    int         hold_left  [2];
    logic [2:0] sw_word = '0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    namur_sensor_channel_conditioner_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    nscc_scoreboard u_scoreboard (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_error_count (error_count),
        .o_outstanding (outstanding)
    );

    // result side back-pressure, one decision per cycle
    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // random level inside one region of the current thresholds
    function automatic int region_level(input int region);
        case (region)
            RegLead:  return $urandom_range(0, lead_lvl);
            RegShort: return $urandom_range(short_lvl, LevelMax);
            RegBand:  return $urandom_range(off_lvl, on_lvl);
            RegHigh:  return $urandom_range(on_lvl, LevelMax);
            RegLow:   return $urandom_range(0, off_lvl);
            default:  return $urandom_range(0, LevelMax);
        endcase
    endfunction

    // next raw sample of a channel; a forced region draws fresh inside it
    function automatic int next_sample(input int ch, input int forced);
        int lvl;
        if (forced != RegFree) return region_level(forced);
        if (hold_left[ch] == 0) begin
            hold_level[ch] = region_level($urandom_range(RegLead, RegAny));
            hold_left[ch]  = $urandom_range(3, 24);
        end
        hold_left[ch] = hold_left[ch] - 1;
        // one beat in eight is pure noise
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, LevelMax);
        lvl = hold_level[ch] + $urandom_range(0, 32) - 16;
        if (lvl < 0) lvl = 0;
        if (lvl > LevelMax) lvl = LevelMax;
        return lvl;
    endfunction

    // one input beat; entered and left at a falling edge
    task automatic send_beat(input int a, input int b, input logic [2:0] sw);
        logic [InWidth-1:0] word;
        if (n_sent < 218) begin
            tx_idle_pct = 29;
            rx_idle_pct = 83;
        end else if (n_sent < 436) begin
            tx_idle_pct = 83;
            rx_idle_pct = 29;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        word = '0;
        word[SampleBits-1:0]            = a[SampleBits-1:0];
        word[2*SampleBits-1:SampleBits] = b[SampleBits-1:0];
        word[2*SampleBits +: 3]         = sw;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        n_sent = n_sent + 1;
        @(negedge clk);
    endtask

    task automatic send_run(input int count, input int a, input int b, input logic [2:0] sw);
        repeat (count) send_beat(a, b, sw);
    endtask

    // random beats; bursts force both channels into one region and keep
    // faults unsuppressed so the blink counter runs long enough to toggle
    task automatic send_random(input int count, input int forced);
        for (int k = 0; k < count; k++) begin
            if (forced != RegFree) sw_word = {2'($urandom_range(0, 3)), 1'b0};
            else if ($urandom_range(0, 15) == 0) sw_word = 3'($urandom_range(0, 7));
            send_beat(next_sample(0, forced), next_sample(1, forced), sw_word);
        end
    endtask

    // hold the sender until every predicted result has been taken
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic apply_settings(input int lead, input int shrt, input int on_l,
                                  input int off_l, input int shift, input int target);
        cfg_we <= 1'b1;
        cfg_index <= CFG_LEAD_BREAK_MAX;
        cfg_data  <= CfgDataBits'(lead);
        @(negedge clk);
        cfg_index <= CFG_SHORT_MIN;
        cfg_data  <= CfgDataBits'(shrt);
        @(negedge clk);
        cfg_index <= CFG_LATCH_ON_LEVEL;
        cfg_data  <= CfgDataBits'(on_l);
        @(negedge clk);
        cfg_index <= CFG_LATCH_OFF_LEVEL;
        cfg_data  <= CfgDataBits'(off_l);
        @(negedge clk);
        cfg_index <= CFG_AVERAGE_SHIFT;
        cfg_data  <= CfgDataBits'(shift);
        @(negedge clk);
        cfg_index <= CFG_DEBOUNCE_TARGET;
        cfg_data  <= CfgDataBits'(target);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        lead_lvl  = lead;
        short_lvl = shrt;
        on_lvl    = on_l;
        off_lvl   = off_l;
    endtask

    initial begin
        hold_left[0] = 0;
        hold_left[1] = 0;
        hold_level[0] = 0;
        hold_level[1] = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed beats at reset settings
        // zero level debounces into lead break on both channels
        send_run(5, 0, 0, 3'b000);
        // suppressed fault: kind clears, latch follows the level
        send_run(1, 0, 0, 3'b001);
        // full-scale step climbs through band and latch on
        send_run(8, LevelMax, LevelMax, 3'b000);
        send_run(4, LevelMax, LevelMax, 3'b110);
        // short level with faults suppressed, channels apart
        send_run(2, LevelMax, 0, 3'b001);
        // mid-scale levels around the hysteresis band, normally closed
        send_run(3, 2047, 1700, 3'b010);
        send_run(2, 1750, 1750, 3'b100);
        settle();

        // typical settings drawn at random
        apply_settings($urandom_range(50, 600), $urandom_range(3400, 4000),
                       $urandom_range(2000, 3000), $urandom_range(800, 1999),
                       $urandom_range(0, 4), $urandom_range(1, 6));
        send_random(100, RegFree);
        settle();

        // widest thresholds, no smoothing, single-beat debounce
        apply_settings(0, LevelMax, LevelMax, 0, 0, 1);
        send_random(60, RegFree);
        settle();

        // overlapping thresholds, smoothing shift of eight, longest debounce
        apply_settings(LevelMax, 0, 0, LevelMax, 8, 255);
        send_random(40, RegFree);
        settle();

        // shift past eight and a zero debounce target
        apply_settings(500, 3500, 2500, 1000, 15, 0);
        send_random(40, RegFree);
        settle();

        // long fault stretches so both blink periods roll over
        apply_settings(300, 3700, 2400, 1600, 1, 2);
        send_random(260, RegLead);
        send_random(110, RegShort);
        send_random(20, RegFree);

        settle();
        repeat (4) @(negedge clk);
        if (error_count == 0 && outstanding == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #400000;
        $display("tb: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/core/nscc_pkg.sv
rtl/core/namur_sensor_channel_conditioner_core.sv
dv/nscc_scoreboard.sv
dv/tb.sv
